// ===== src/rcpd_pkg.sv =====
// Package for the RC receiver PPM/PWM pulse decoder.
// Holds the timing thresholds, the field widths and the default channel count.
// No dependencies; used by rc_ppm_pwm_input_decoder_top.
`timescale 1ns / 1ps

package rcpd_pkg;

    localparam int NUM_CHANNELS_DEF = 8;

    localparam int CH_W    = 3;
    localparam int STAMP_W = 16;
    localparam int WIDTH_W = 16;

    localparam int S_TDATA_W = 24;  // channel + stamp, padded to bytes
    localparam int M_TDATA_W = 24;  // width + rc_active + expect_rising, padded

    localparam logic [STAMP_W-1:0] PPM_SYNC_GAP  = 16'd4000;
    localparam logic [STAMP_W-1:0] PPM_MIN_PULSE = 16'd750;
    localparam logic [STAMP_W-1:0] PPM_MAX_PULSE = 16'd2250;
    localparam logic [WIDTH_W-1:0] CENTER_WIDTH  = 16'd1500;

    typedef enum logic {
        MODE_CAPTURE = 1'b0,
        MODE_READ    = 1'b1
    } t_mode;

    // Interval between two timer stamps. A later stamp gives the plain
    // difference; otherwise the interval is one count short of the
    // difference, so equal stamps give all ones.
    function automatic logic [STAMP_W-1:0] wrap_interval(
        input logic [STAMP_W-1:0] from_stamp,
        input logic [STAMP_W-1:0] to_stamp
    );
        logic [STAMP_W-1:0] diff;
        diff = to_stamp - from_stamp;
        if (to_stamp > from_stamp) begin
            return diff;
        end
        return diff - STAMP_W'(1);
    endfunction

endpackage

// ===== src/rc_ppm_pwm_input_decoder_top.sv =====
// Top level of the RC receiver PPM/PWM pulse decoder.
// Depends on rcpd_pkg for thresholds, widths and the wrap function.
//
//  Channel  | Direction | tdata (low bit up)                      | tuser
//  ---------+-----------+-----------------------------------------+-------
//  s (in)   | request   | channel[2:0], stamp[18:3]               | mode
//  m (out)  | result    | width[15:0], rc_active[16], exp_rise[17] | -
//  cfg      | write     | use_ppm (1 bit)                         | -
//
// One request is taken per cycle while the output is not stalled. A request is held
// in the input register, then the decode and state update happen in one pass and
// the result lands in the output register.
// Reset is synchronous and active low; it restores every width to 1500.
// A stalled output holds the result; the input register still empties into it
// in the same cycle the result is taken.
`timescale 1ns / 1ps

module rc_ppm_pwm_input_decoder_top #(
    parameter int NUM_CHANNELS = rcpd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,   // use_ppm
    // request stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [rcpd_pkg::S_TDATA_W-1:0] i_s_tdata,     // channel, stamp, zeros
    input  logic                           i_s_tuser,     // mode
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [rcpd_pkg::M_TDATA_W-1:0] o_m_tdata      // width, rc_active,
                                                          // expect_rising, zeros
);
    import rcpd_pkg::*;

    localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SLOT_W = $clog2(NUM_CHANNELS + 1);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(NUM_CHANNELS);

    // Input register
    logic               r_in_valid;
    t_mode              r_in_mode;
    logic [CH_W-1:0]    r_in_ch;
    logic [STAMP_W-1:0] r_in_stamp;

    // Decoder state
    logic                r_use_ppm;
    logic [WIDTH_W-1:0]  r_pulse_width [NUM_CHANNELS];
    logic [STAMP_W-1:0]  r_rise_stamp  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_high_phase;
    logic [STAMP_W-1:0]  r_ppm_now;
    logic [SLOT_W-1:0]   r_ppm_slot;
    logic                r_seen_active;

    logic [WIDTH_W-1:0]  n_pulse_width [NUM_CHANNELS];
    logic [STAMP_W-1:0]  n_rise_stamp  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] n_high_phase;
    logic [STAMP_W-1:0]  n_ppm_now;
    logic [SLOT_W-1:0]   n_ppm_slot;
    logic                n_seen_active;

    // Output register
    logic                 r_out_valid;
    logic [WIDTH_W-1:0]   r_out_width;
    logic                 r_out_active;
    logic                 r_out_rising;
    logic [WIDTH_W-1:0]   n_out_width;
    logic                 n_out_rising;

    logic               advance;
    logic               ch_valid;
    logic [IDX_W-1:0]   ch_idx;
    logic [IDX_W-1:0]   slot_idx;
    logic [STAMP_W-1:0] ppm_gap;
    logic [STAMP_W-1:0] pwm_gap;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    assign ch_valid = 32'(r_in_ch) < NUM_CHANNELS;
    assign ch_idx   = IDX_W'(r_in_ch);
    assign slot_idx = IDX_W'(r_ppm_slot);
    assign ppm_gap  = wrap_interval(r_ppm_now, r_in_stamp);
    assign pwm_gap  = wrap_interval(r_rise_stamp[ch_idx], r_in_stamp);

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            n_pulse_width[i] = r_pulse_width[i];
            n_rise_stamp[i]  = r_rise_stamp[i];
        end
        n_high_phase  = r_high_phase;
        n_ppm_now     = r_ppm_now;
        n_ppm_slot    = r_ppm_slot;
        n_seen_active = r_seen_active;

        if (r_in_mode == MODE_CAPTURE) begin
            if (r_use_ppm) begin
                if (r_in_ch == '0) begin
                    n_ppm_now     = r_in_stamp;
                    n_seen_active = 1'b1;
                    if (ppm_gap > PPM_SYNC_GAP) begin
                        n_ppm_slot = '0;
                    end else if (r_ppm_slot < SLOT_MAX) begin
                        if (ppm_gap > PPM_MIN_PULSE && ppm_gap < PPM_MAX_PULSE) begin
                            n_pulse_width[slot_idx] = ppm_gap;
                        end
                        n_ppm_slot = r_ppm_slot + SLOT_W'(1);
                    end
                end
            end else if (ch_valid) begin
                if (r_in_ch == '0) begin
                    n_seen_active = 1'b1;
                end
                if (!r_high_phase[ch_idx]) begin
                    n_rise_stamp[ch_idx] = r_in_stamp;
                    n_high_phase[ch_idx] = 1'b1;
                end else begin
                    n_pulse_width[ch_idx] = pwm_gap;
                    n_high_phase[ch_idx]  = 1'b0;
                end
            end
        end

        n_out_width  = ch_valid ? n_pulse_width[ch_idx] : '0;
        n_out_rising = ch_valid && !r_use_ppm && !n_high_phase[ch_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode  <= t_mode'(i_s_tuser);
            r_in_ch    <= i_s_tdata[CH_W-1:0];
            r_in_stamp <= i_s_tdata[CH_W +: STAMP_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_ppm <= 1'b0;
        end else if (i_cfg_we) begin
            r_use_ppm <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_pulse_width[i] <= CENTER_WIDTH;
                r_rise_stamp[i]  <= '0;
            end
            r_high_phase  <= '0;
            r_ppm_now     <= '0;
            r_ppm_slot    <= '0;
            r_seen_active <= 1'b0;
        end else if (advance) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_pulse_width[i] <= n_pulse_width[i];
                r_rise_stamp[i]  <= n_rise_stamp[i];
            end
            r_high_phase  <= n_high_phase;
            r_ppm_now     <= n_ppm_now;
            r_ppm_slot    <= n_ppm_slot;
            r_seen_active <= n_seen_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_width  <= n_out_width;
            r_out_active <= n_seen_active;
            r_out_rising <= n_out_rising;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - WIDTH_W - 2)'(0), r_out_rising, r_out_active,
                         r_out_width};

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for rc_ppm_pwm_input_decoder_top: PWM and PPM decode, reads,
// back-pressure. Every request is predicted in the bench and compared with its result.
// Depends on rcpd_pkg and the decoder top level.
`timescale 1ns / 1ps

module tb;
    import rcpd_pkg::*;

    localparam int NCH        = NUM_CHANNELS_DEF;
    localparam int IDLE_PCT   = 31;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic               rc_active;
        logic               expect_rising;
    } t_decode_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_wdata = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;   // channel, stamp, zeros
    logic                  i_s_tuser = 1'b0;  // mode
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;         // width, rc_active, expect_rising, zeros

    rc_ppm_pwm_input_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Decoder state as the bench sees it.
    logic [WIDTH_W-1:0] chan_width [NCH];
    logic [STAMP_W-1:0] chan_rise  [NCH];
    logic               chan_high  [NCH];
    logic [STAMP_W-1:0] frame_cur;
    logic [STAMP_W-1:0] frame_prev;
    logic [3:0]         frame_slot;
    logic               ch0_seen;
    logic               ppm_on;

    t_decode_result pending_results[$];
    int             mismatches = 0;
    int             requests_sent = 0;
    int             cycles = 0;
    bit             tx_idle_on = 1'b1;
    bit             rx_idle_on = 1'b1;
    int             rx_hold_cycles = 0;
    logic [STAMP_W-1:0] ppm_stamp;

    // Timer interval; a stamp that is not later than the start counts one short.
    function automatic logic [STAMP_W-1:0] stamp_interval(logic [STAMP_W-1:0] from_s,
                                                          logic [STAMP_W-1:0] to_s);
        if (to_s > from_s) return to_s - from_s;
        return 16'hFFFF - from_s + to_s;
    endfunction

    function automatic t_decode_result decode_request(t_mode mode, logic [CH_W-1:0] ch,
                                                      logic [STAMP_W-1:0] stamp);
        logic [STAMP_W-1:0] gap;
        t_decode_result     r;
        if (mode == MODE_CAPTURE) begin
            if (ppm_on) begin
                if (ch == 0) begin
                    frame_prev = frame_cur;
                    frame_cur  = stamp;
                    ch0_seen   = 1'b1;
                    gap = stamp_interval(frame_prev, frame_cur);
                    if (gap > PPM_SYNC_GAP) begin
                        frame_slot = 4'd0;
                    end else if (frame_slot < 4'(NCH)) begin
                        if (gap > PPM_MIN_PULSE && gap < PPM_MAX_PULSE)
                            chan_width[frame_slot[CH_W-1:0]] = gap;
                        frame_slot = frame_slot + 4'd1;
                    end
                end
            end else begin
                if (ch == 0) ch0_seen = 1'b1;
                if (!chan_high[ch]) begin
                    chan_rise[ch] = stamp;
                    chan_high[ch] = 1'b1;
                end else begin
                    chan_width[ch] = stamp_interval(chan_rise[ch], stamp);
                    chan_high[ch]  = 1'b0;
                end
            end
        end
        r.width         = chan_width[ch];
        r.rc_active     = ch0_seen;
        r.expect_rising = !ppm_on && !chan_high[ch];
        return r;
    endfunction

    // Sends one request, with random idle cycles ahead of it while tx_idle_on is set, and records its result.
    task automatic send_request(t_mode mode, logic [CH_W-1:0] ch, logic [STAMP_W-1:0] stamp);
        @(negedge i_clk);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= S_TDATA_W'({stamp, ch});
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(decode_request(mode, ch, stamp));
        requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // The block holds no request once every result is back, so the write is safe here.
    task automatic write_use_ppm(logic value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        ppm_on = value;
    endtask

    task automatic test_reset_values();
        send_request(MODE_READ, 3'd0, 16'hFFFF);
        send_request(MODE_READ, 3'd7, 16'h0000);
        send_request(MODE_READ, 3'd3, 16'hA5A5);
    endtask

    task automatic test_pwm_edges();
        send_request(MODE_CAPTURE, 3'd0, 16'd100);
        send_request(MODE_CAPTURE, 3'd0, 16'd1600);
        // Fall after the timer wrapped.
        send_request(MODE_CAPTURE, 3'd1, 16'd65000);
        send_request(MODE_CAPTURE, 3'd1, 16'd500);
        // Equal stamps give all ones.
        send_request(MODE_CAPTURE, 3'd2, 16'd1234);
        send_request(MODE_CAPTURE, 3'd2, 16'd1234);
        send_request(MODE_CAPTURE, 3'd7, 16'hFFFF);
        send_request(MODE_CAPTURE, 3'd7, 16'h0000);
        // A read in the middle of a pulse shows the channel waiting for its fall.
        send_request(MODE_CAPTURE, 3'd5, 16'd0);
        send_request(MODE_READ, 3'd5, 16'h5A5A);
    endtask

    task automatic test_ppm_frame_rules();
        send_request(MODE_CAPTURE, 3'd0, 16'd10000);   // long gap, new frame
        send_request(MODE_CAPTURE, 3'd0, 16'd11000);   // stored in slot 0
        send_request(MODE_CAPTURE, 3'd0, 16'd11750);   // lower bound, not stored
        send_request(MODE_CAPTURE, 3'd0, 16'd14000);   // upper bound, not stored
        send_request(MODE_CAPTURE, 3'd0, 16'd14751);
        send_request(MODE_CAPTURE, 3'd0, 16'd17000);
        send_request(MODE_CAPTURE, 3'd0, 16'd21000);   // exactly the sync gap is no sync
        send_request(MODE_CAPTURE, 3'd0, 16'd25001);
        send_request(MODE_READ, 3'd3, 16'd0);
        send_request(MODE_CAPTURE, 3'd3, 16'd0);       // other channels are ignored
        ppm_stamp = 16'd25001;
    endtask

    // Mostly complete rise/fall pairs with random content, plus reads and stray edges.
    task automatic run_pwm_traffic(int n);
        int                  target;
        int                  pick;
        logic [CH_W-1:0]     ch;
        logic [STAMP_W-1:0]  rise;
        logic [STAMP_W-1:0]  pulse;
        target = requests_sent + n;
        while (requests_sent < target) begin
            pick = $urandom_range(99);
            ch   = CH_W'($urandom_range(NCH - 1));
            if (pick < 15) begin
                send_request(MODE_READ, ch, STAMP_W'($urandom_range(16'hFFFF)));
            end else if (pick < 25) begin
                send_request(MODE_CAPTURE, ch, STAMP_W'($urandom_range(16'hFFFF)));
            end else begin
                if (chan_high[ch])
                    send_request(MODE_CAPTURE, ch, STAMP_W'($urandom_range(16'hFFFF)));
                rise  = STAMP_W'($urandom_range(16'hFFFF));
                pulse = ($urandom_range(3) == 0) ? STAMP_W'($urandom_range(16'hFFFF))
                                                 : STAMP_W'($urandom_range(2100, 900));
                send_request(MODE_CAPTURE, ch, rise);
                send_request(MODE_CAPTURE, ch, rise + pulse);
            end
        end
    endtask

    // Frames of a sync gap and a random number of pulses, with some noise between them.
    task automatic run_ppm_traffic(int n);
        int                  target;
        int                  pulses;
        int                  pick;
        logic [STAMP_W-1:0]  gap;
        target = requests_sent + n;
        while (requests_sent < target) begin
            ppm_stamp = ppm_stamp + STAMP_W'($urandom_range(60000, 4001));
            send_request(MODE_CAPTURE, 3'd0, ppm_stamp);
            pulses = $urandom_range(12, 1);
            for (int i = 0; i < pulses; i++) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    gap = STAMP_W'($urandom_range(2249, 751));
                end else begin
                    case ($urandom_range(4))
                        0: gap = PPM_MIN_PULSE;
                        1: gap = PPM_MAX_PULSE;
                        2: gap = PPM_SYNC_GAP;
                        3: gap = 16'd0;
                        default: gap = STAMP_W'($urandom_range(4000));
                    endcase
                end
                ppm_stamp = ppm_stamp + gap;
                send_request(MODE_CAPTURE, 3'd0, ppm_stamp);
                pick = $urandom_range(99);
                if (pick < 10) begin
                    send_request(MODE_READ, CH_W'($urandom_range(NCH - 1)),
                                 STAMP_W'($urandom_range(16'hFFFF)));
                end else if (pick < 15) begin
                    send_request(MODE_CAPTURE, CH_W'($urandom_range(NCH - 1, 1)),
                                 STAMP_W'($urandom_range(16'hFFFF)));
                end else if (pick < 18) begin
                    ppm_stamp = STAMP_W'($urandom_range(16'hFFFF));
                    send_request(MODE_CAPTURE, 3'd0, ppm_stamp);
                end
            end
        end
    endtask

    // The receiver stops for a long time while requests keep coming.
    task automatic test_result_stall();
        rx_hold_cycles = 300;
        run_pwm_traffic(60);
        wait_drained();
    endtask

    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_ppm_traffic(200);
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < NCH; i++) begin
            chan_width[i] = CENTER_WIDTH;
            chan_rise[i]  = '0;
            chan_high[i]  = 1'b0;
        end
        frame_cur  = '0;
        frame_prev = '0;
        frame_slot = '0;
        ch0_seen   = 1'b0;
        ppm_on     = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_use_ppm(1'b0);
        test_reset_values();
        test_pwm_edges();
        write_use_ppm(1'b1);
        test_ppm_frame_rules();
        write_use_ppm(1'b0);
        run_pwm_traffic(350);
        write_use_ppm(1'b1);
        run_ppm_traffic(350);
        test_result_stall();
        write_use_ppm(1'b0);
        run_pwm_traffic(300);
        test_full_rate();
        write_use_ppm(1'b1);
        run_ppm_traffic(300);
        test_full_rate();
        write_use_ppm(1'b0);
        run_pwm_traffic(200);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: random stalls or always ready, or a counted hold-off when a test asks for one.
    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles != 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                i_m_tready <= 1'b0;
                repeat (hold - 1) @(negedge i_clk);
            end else if (rx_idle_on) begin
                i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_decode_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: tdata %h", o_m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[15:0] !== want.width) begin
                    $error("width: expected %0d, actual %0d", want.width, o_m_tdata[15:0]);
                    mismatches++;
                end
                if (o_m_tdata[16] !== want.rc_active) begin
                    $error("rc_active: expected %0b, actual %0b", want.rc_active,
                           o_m_tdata[16]);
                    mismatches++;
                end
                if (o_m_tdata[17] !== want.expect_rising) begin
                    $error("expect_rising: expected %0b, actual %0b", want.expect_rising,
                           o_m_tdata[17]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// ===== rc_ppm_pwm_input_decoder_top.f =====
src/rcpd_pkg.sv
src/rc_ppm_pwm_input_decoder_top.sv
tb/tb.sv
